[rtl/mvw_pkg.sv]
// Shared types and constants for the vertex weld block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mvw_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int COUNT_W   = NODE_AW + 1;
    localparam int INDEX_W   = 10;
    localparam int COORD_W   = 32;
    localparam int EPS_W     = 63;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(65536);

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      last_vertex;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] node_index;
        logic               is_new;
        logic               overflow;
        logic [1:0]         corner;
    } out_word_t;

    typedef struct packed {
        logic               load;
        logic               rd_en;
        logic [NODE_AW-1:0] rd_addr;
        logic               flush;
        logic               finish;
        logic               wr_en;
        logic [NODE_AW-1:0] wr_addr;
        out_word_t          result;
    } cmd_t;

    typedef struct packed {
        logic               hit_valid;
        logic [NODE_AW-1:0] hit_idx;
        logic               pipe_busy;
        logic               out_free;
        logic               last;
    } status_t;

endpackage

[rtl/mesh_vertex_weld.sv]
// Top level of the vertex weld block: joins controller and datapath.
// Depends on mvw_pkg, mvw_controller and mvw_datapath.
//
// Use: vertices enter on the s_ channel as one word of x, y, z (signed
// Q16.16) and a last flag; one result word leaves on the m_ channel per
// vertex with the node index, new and overflow flags and the corner number.
// The cfg_ channel writes the squared merge distance and is always ready;
// it must be written only while no vertex is in flight (not enforced).
// Timing: the stored vertices are read from the table one per cycle in order
// through a five-stage distance pipeline; the search stops at the first hit.
// One vertex is worked on at a time; the next one is taken only once the
// previous result has been written into the output register.
// Reset empties the table, zeroes the corner count and sets the distance to
// 65536. When the receiver stalls, the result waits in the output register
// and a following vertex is accepted and searched, but holds at its finish
// until the output register is free.
module mesh_vertex_weld (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  mvw_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output mvw_pkg::out_word_t         m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mvw_pkg::EPS_W-1:0]  cfg_data
);

    mvw_pkg::cmd_t    cmd;
    mvw_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mvw_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mvw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[rtl/mvw_datapath.sv]
// Datapath of the vertex weld block: vertex store, distance pipeline,
// epsilon register and output register. Depends on mvw_pkg.
module mvw_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mvw_pkg::in_word_t           s_data,
    input  logic                        cfg_valid,
    input  logic [mvw_pkg::EPS_W-1:0]   cfg_data,
    input  mvw_pkg::cmd_t               cmd,
    output mvw_pkg::status_t            status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mvw_pkg::out_word_t          m_data
);

    localparam int VW = 3 * mvw_pkg::COORD_W;

    logic [VW-1:0] mem [mvw_pkg::MAX_NODES];

    mvw_pkg::in_word_t             in_reg;
    logic [mvw_pkg::EPS_W-1:0]     eps_reg;
    logic [VW-1:0]                 rdata_reg;
    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [mvw_pkg::NODE_AW-1:0]   i1_reg, i2_reg, i3_reg, i4_reg, i5_reg;
    logic [mvw_pkg::COORD_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [mvw_pkg::SQ_W-1:0]      sx_reg, sy_reg, sz_reg;
    logic [mvw_pkg::SUM_W-1:0]     sum_reg;
    logic                          hit_reg;
    logic                          m_valid_reg;
    mvw_pkg::out_word_t            m_data_reg;

    logic signed [mvw_pkg::COORD_W-1:0] rx, ry, rz;
    logic [mvw_pkg::COORD_W-1:0]        ax_next, ay_next, az_next;

    function automatic logic [mvw_pkg::COORD_W-1:0] abs_diff(
        input logic signed [mvw_pkg::COORD_W-1:0] a,
        input logic signed [mvw_pkg::COORD_W-1:0] b
    );
        logic signed [mvw_pkg::COORD_W:0] d;
        logic signed [mvw_pkg::COORD_W:0] m;
        d = {a[mvw_pkg::COORD_W-1], a} - {b[mvw_pkg::COORD_W-1], b};
        m = d[mvw_pkg::COORD_W] ? -d : d;
        return m[mvw_pkg::COORD_W-1:0];
    endfunction

    assign rx = rdata_reg[VW-1 -: mvw_pkg::COORD_W];
    assign ry = rdata_reg[VW-1-mvw_pkg::COORD_W -: mvw_pkg::COORD_W];
    assign rz = rdata_reg[mvw_pkg::COORD_W-1:0];

    assign ax_next = abs_diff(in_reg.coord_x, rx);
    assign ay_next = abs_diff(in_reg.coord_y, ry);
    assign az_next = abs_diff(in_reg.coord_z, rz);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= {in_reg.coord_x, in_reg.coord_y, in_reg.coord_z};
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            eps_reg     <= mvw_pkg::EPS_RESET;
        end else begin
            if (cmd.flush) begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                v3_reg <= 1'b0;
                v4_reg <= 1'b0;
                v5_reg <= 1'b0;
            end else begin
                v1_reg <= cmd.rd_en;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                eps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.finish) begin
            m_data_reg <= cmd.result;
        end
        i1_reg  <= cmd.rd_addr;
        i2_reg  <= i1_reg;
        i3_reg  <= i2_reg;
        i4_reg  <= i3_reg;
        i5_reg  <= i4_reg;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        sx_reg  <= mvw_pkg::SQ_W'(ax_reg) * mvw_pkg::SQ_W'(ax_reg);
        sy_reg  <= mvw_pkg::SQ_W'(ay_reg) * mvw_pkg::SQ_W'(ay_reg);
        sz_reg  <= mvw_pkg::SQ_W'(az_reg) * mvw_pkg::SQ_W'(az_reg);
        sum_reg <= mvw_pkg::SUM_W'(sx_reg) + mvw_pkg::SUM_W'(sy_reg)
                 + mvw_pkg::SUM_W'(sz_reg);
        hit_reg <= sum_reg < mvw_pkg::SUM_W'(eps_reg);
    end

    assign status.hit_valid = v5_reg && hit_reg;
    assign status.hit_idx   = i5_reg;
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.last      = in_reg.last_vertex;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/mvw_controller.sv]
// Controller of the vertex weld block: input handshake, search sequencing,
// table count and corner count. Depends on mvw_pkg.
module mvw_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mvw_pkg::status_t  status,
    output mvw_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [mvw_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [mvw_pkg::COUNT_W-1:0]   issue_reg, issue_next;
    logic [1:0]                    corner_reg, corner_next;
    logic                          found_reg, found_next;
    logic [mvw_pkg::NODE_AW-1:0]   idx_reg, idx_next;
    logic                          more;
    logic                          room;

    assign more = issue_reg < count_reg;
    assign room = count_reg < mvw_pkg::COUNT_W'(mvw_pkg::MAX_NODES);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        corner_next = corner_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.rd_addr = issue_reg[mvw_pkg::NODE_AW-1:0];
        cmd.wr_addr = count_reg[mvw_pkg::NODE_AW-1:0];
        cmd.result.corner   = corner_reg;
        cmd.result.is_new   = !found_reg && room;
        cmd.result.overflow = !found_reg && !room;
        if (found_reg) begin
            cmd.result.node_index = mvw_pkg::INDEX_W'(idx_reg);
        end else if (room) begin
            cmd.result.node_index = mvw_pkg::INDEX_W'(count_reg);
        end else begin
            cmd.result.node_index = '0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (status.hit_valid) begin
                    cmd.flush  = 1'b1;
                    found_next = 1'b1;
                    idx_next   = status.hit_idx;
                    state_next = ST_FINISH;
                end else if (more) begin
                    cmd.rd_en  = 1'b1;
                    issue_next = issue_reg + mvw_pkg::COUNT_W'(1);
                end else if (!status.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    cmd.wr_en  = !found_reg && room;
                    if (!found_reg && room) begin
                        count_next = count_reg + mvw_pkg::COUNT_W'(1);
                    end
                    corner_next = (corner_reg >= 2'd2) ? 2'd0 : corner_reg + 2'd1;
                    if (status.last) begin
                        count_next  = '0;
                        corner_next = 2'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            issue_reg  <= '0;
            corner_reg <= 2'd0;
            found_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            corner_reg <= corner_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

endmodule

[tb/mesh_vertex_weld_tb.sv]
// Testbench for mesh_vertex_weld: drives vertex words, the merge distance and random stalls.
// A predictor class tracks the vertex table and checks each result word in order.
// Depends on mvw_pkg and the mesh_vertex_weld RTL.
module mesh_vertex_weld_tb;

    localparam int unsigned LIMIT_CYCLES = 8_000_000;
    localparam int unsigned RANDOM_WORDS = 580;
    localparam int unsigned QUIET_WORDS  = 60;
    localparam int unsigned DRAIN_CYCLES = 1100;

    typedef enum {COORD_FULL, COORD_SMALL, COORD_EDGE} coord_kind_t;

    class weld_tracker;
        logic [mvw_pkg::COORD_W-1:0] node_x [mvw_pkg::MAX_NODES];
        logic [mvw_pkg::COORD_W-1:0] node_y [mvw_pkg::MAX_NODES];
        logic [mvw_pkg::COORD_W-1:0] node_z [mvw_pkg::MAX_NODES];
        int unsigned                 node_total;
        int unsigned                 corner_next;
        logic [mvw_pkg::EPS_W-1:0]   eps_sq;
        mvw_pkg::out_word_t          pending_words[$];
        int unsigned                 fail_count;

        function new();
            node_total  = 0;
            corner_next = 0;
            eps_sq      = mvw_pkg::EPS_RESET;
            fail_count  = 0;
        endfunction

        function void set_eps(logic [mvw_pkg::EPS_W-1:0] value);
            eps_sq = value;
        endfunction

        function bit busy();
            return pending_words.size() != 0;
        endfunction

        function logic [mvw_pkg::SQ_W-1:0] axis_sq(logic [mvw_pkg::COORD_W-1:0] a,
                                                   logic [mvw_pkg::COORD_W-1:0] b);
            logic [mvw_pkg::COORD_W:0] d;
            logic [mvw_pkg::SQ_W-1:0]  m;
            d = {a[mvw_pkg::COORD_W-1], a} - {b[mvw_pkg::COORD_W-1], b};
            if (d[mvw_pkg::COORD_W]) d = -d;
            m = mvw_pkg::SQ_W'(d);
            return m * m;
        endfunction

        // saturate the sum of squares at all ones
        function logic [mvw_pkg::SQ_W-1:0] span_sq(int unsigned i, mvw_pkg::in_word_t w);
            logic [mvw_pkg::SUM_W-1:0] s;
            s = {2'b00, axis_sq(node_x[i], w.coord_x)}
              + {2'b00, axis_sq(node_y[i], w.coord_y)}
              + {2'b00, axis_sq(node_z[i], w.coord_z)};
            return (s[mvw_pkg::SUM_W-1:mvw_pkg::SQ_W] != 2'b00) ? {mvw_pkg::SQ_W{1'b1}}
                                                                : s[mvw_pkg::SQ_W-1:0];
        endfunction

        function void note_vertex(mvw_pkg::in_word_t w);
            mvw_pkg::out_word_t e;
            bit                 hit;
            e   = '0;
            hit = 1'b0;
            for (int unsigned i = 0; i < node_total && !hit; i++) begin
                if (span_sq(i, w) < {1'b0, eps_sq}) begin
                    hit          = 1'b1;
                    e.node_index = mvw_pkg::INDEX_W'(i);
                end
            end
            if (!hit) begin
                if (node_total < mvw_pkg::MAX_NODES) begin
                    node_x[node_total] = w.coord_x;
                    node_y[node_total] = w.coord_y;
                    node_z[node_total] = w.coord_z;
                    e.node_index       = mvw_pkg::INDEX_W'(node_total);
                    e.is_new           = 1'b1;
                    node_total++;
                end else begin
                    e.overflow = 1'b1;
                end
            end
            e.corner    = 2'(corner_next);
            corner_next = (corner_next >= 2) ? 0 : corner_next + 1;
            if (w.last_vertex) begin
                node_total  = 0;
                corner_next = 0;
            end
            pending_words.push_back(e);
        endfunction

        function void check_word(mvw_pkg::out_word_t got);
            mvw_pkg::out_word_t e;
            if (pending_words.size() == 0) begin
                $error("result word with no vertex pending: node_index %0d", got.node_index);
                fail_count++;
                return;
            end
            e = pending_words.pop_front();
            if (got.node_index !== e.node_index) begin
                $error("node_index: expected %0d, got %0d", e.node_index, got.node_index);
                fail_count++;
            end
            if (got.is_new !== e.is_new) begin
                $error("is_new: expected %0d, got %0d", e.is_new, got.is_new);
                fail_count++;
            end
            if (got.overflow !== e.overflow) begin
                $error("overflow: expected %0d, got %0d", e.overflow, got.overflow);
                fail_count++;
            end
            if (got.corner !== e.corner) begin
                $error("corner: expected %0d, got %0d", e.corner, got.corner);
                fail_count++;
            end
        endfunction
    endclass

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    mvw_pkg::in_word_t         s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b1;
    mvw_pkg::out_word_t        m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [mvw_pkg::EPS_W-1:0] cfg_data  = '0;

    weld_tracker welds;
    bit          tail_quiet  = 1'b0;
    bit          send_calm   = 1'b0;
    bit          recv_calm   = 1'b0;
    int          stall_left  = 0;
    int unsigned cycle_count = 0;

    mesh_vertex_weld uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) welds.note_vertex(s_data);
            if (m_valid && m_ready) welds.check_word(m_data);
            if (cfg_valid && cfg_ready) welds.set_eps(cfg_data);
        end
    end

    // stall the result side in bursts of random length
    always @(posedge aclk) begin
        if (!aresetn || tail_quiet) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!recv_calm && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            m_ready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0) recv_calm <= ~recv_calm;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic mvw_pkg::in_word_t make_vertex(logic [31:0] x, logic [31:0] y,
                                                      logic [31:0] z, logic last);
        mvw_pkg::in_word_t w;
        w.coord_x     = x;
        w.coord_y     = y;
        w.coord_z     = z;
        w.last_vertex = last;
        return w;
    endfunction

    function automatic logic [31:0] nudge(logic [31:0] c);
        int unsigned span;
        if ($urandom_range(0, 2) == 0) return c;
        span = 1 << $urandom_range(0, 24);
        return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [31:0] fresh_coord(coord_kind_t kind);
        if (kind == COORD_FULL) return $urandom;
        if (kind == COORD_SMALL) return 32'($urandom_range(0, 4095)) - 32'd2048;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    task automatic send_vertex(input mvw_pkg::in_word_t w);
        int gap;
        if (!tail_quiet && !send_calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_eps(input logic [mvw_pkg::EPS_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (welds.busy()) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        mvw_pkg::in_word_t         v;
        mvw_pkg::in_word_t         surface_pts[$];
        mvw_pkg::in_word_t         fill_pts[mvw_pkg::MAX_NODES];
        logic [mvw_pkg::EPS_W-1:0] eps;
        int unsigned               sent;
        int unsigned               phase_end;
        int unsigned               surf_len;
        int unsigned               pick;
        coord_kind_t               kind;

        welds = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // distance at its reset value: strict boundary, saturation, last mark
        send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b0));
        send_vertex(make_vertex(32'h0, 32'h0, 32'd255, 1'b0));
        send_vertex(make_vertex(32'h0, 32'h0, 32'd256, 1'b0));
        send_vertex(make_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0));
        send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FF00, 1'b0));
        send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b1));
        send_vertex(make_vertex(32'h0, 32'h0, 32'd256, 1'b0));
        send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b1));

        // zero distance: duplicates are stored again
        write_eps('0);
        send_vertex(make_vertex(32'd5, 32'd5, 32'd5, 1'b0));
        send_vertex(make_vertex(32'd5, 32'd5, 32'd5, 1'b0));
        send_vertex(make_vertex(32'd5, 32'd5, 32'd5, 1'b1));

        // widest distance
        write_eps({mvw_pkg::EPS_W{1'b1}});
        send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b0));
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0));
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
        send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 1'b1));

        // fill the table, then hit its ends and overflow it
        write_eps(mvw_pkg::EPS_W'(1));
        for (int unsigned j = 0; j < mvw_pkg::MAX_NODES; j++) begin
            fill_pts[j] = make_vertex($urandom, $urandom, $urandom, 1'b0);
            send_vertex(fill_pts[j]);
        end
        send_vertex(fill_pts[mvw_pkg::MAX_NODES-1]);
        send_vertex(fill_pts[0]);
        send_vertex(make_vertex($urandom, $urandom, $urandom, 1'b0));
        send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0));
        v = fill_pts[mvw_pkg::MAX_NODES/2];
        v.last_vertex = 1'b1;
        send_vertex(v);
        send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b1));

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 5))
                0: eps = '0;
                1: eps = mvw_pkg::EPS_W'(1);
                2: eps = mvw_pkg::EPS_RESET;
                3: eps = {mvw_pkg::EPS_W{1'b1}};
                4: eps = mvw_pkg::EPS_W'({$urandom, $urandom});
                default: eps = mvw_pkg::EPS_W'(1) << $urandom_range(0, mvw_pkg::EPS_W - 1);
            endcase
            write_eps(eps);
            phase_end = sent + $urandom_range(60, 120);
            while (sent < phase_end && sent < RANDOM_WORDS) begin
                surf_len  = $urandom_range(1, 40);
                send_calm = ($urandom_range(0, 4) == 0);
                surface_pts.delete();
                for (int unsigned j = 0; j < surf_len; j++) begin
                    if (sent >= RANDOM_WORDS - QUIET_WORDS) tail_quiet <= 1'b1;
                    pick = $urandom_range(0, 9);
                    if (pick < 5 && surface_pts.size() != 0) begin
                        v = surface_pts[$urandom_range(0, surface_pts.size() - 1)];
                        v.coord_x = nudge(v.coord_x);
                        v.coord_y = nudge(v.coord_y);
                        v.coord_z = nudge(v.coord_z);
                    end else begin
                        kind = (pick < 8) ? COORD_FULL : (pick == 8) ? COORD_SMALL : COORD_EDGE;
                        v = make_vertex(fresh_coord(kind), fresh_coord(kind),
                                        fresh_coord(kind), 1'b0);
                    end
                    v.last_vertex = (j == surf_len - 1);
                    surface_pts.push_back(v);
                    send_vertex(v);
                    sent++;
                end
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (welds.busy()) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (welds.fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
